FILE: hdl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the 1-Wire bit-slot master: command codes,
// register indexes and defaults, and the item and register bank structures.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int LineWidth  = 8;
	localparam int DelayWidth = 10;
	localparam int OpWidth    = 3;
	localparam int IndexWidth = 3;

	// command codes
	localparam logic [OpWidth-1:0] OP_INIT     = 3'd0;
	localparam logic [OpWidth-1:0] OP_WRITE0   = 3'd1;
	localparam logic [OpWidth-1:0] OP_WRITE1   = 3'd2;
	localparam logic [OpWidth-1:0] OP_READ     = 3'd3;
	localparam logic [OpWidth-1:0] OP_PRESENCE = 3'd4;

	// register indexes
	localparam logic [IndexWidth-1:0] REG_SHORT_LOW       = 3'd0;
	localparam logic [IndexWidth-1:0] REG_ONE_RECOVER     = 3'd1;
	localparam logic [IndexWidth-1:0] REG_ZERO_LOW        = 3'd2;
	localparam logic [IndexWidth-1:0] REG_ZERO_RECOVER    = 3'd3;
	localparam logic [IndexWidth-1:0] REG_READ_SAMPLE     = 3'd4;
	localparam logic [IndexWidth-1:0] REG_RESET_LOW       = 3'd5;
	localparam logic [IndexWidth-1:0] REG_PRESENCE_SAMPLE = 3'd6;
	localparam logic [IndexWidth-1:0] REG_PRESENCE_TAIL   = 3'd7;

	// register defaults
	localparam logic [DelayWidth-1:0] RST_SHORT_LOW       = 10'd6;
	localparam logic [DelayWidth-1:0] RST_ONE_RECOVER     = 10'd64;
	localparam logic [DelayWidth-1:0] RST_ZERO_LOW        = 10'd60;
	localparam logic [DelayWidth-1:0] RST_ZERO_RECOVER    = 10'd10;
	localparam logic [DelayWidth-1:0] RST_READ_SAMPLE     = 10'd9;
	localparam logic [DelayWidth-1:0] RST_RESET_LOW       = 10'd480;
	localparam logic [DelayWidth-1:0] RST_PRESENCE_SAMPLE = 10'd70;
	localparam logic [DelayWidth-1:0] RST_PRESENCE_TAIL   = 10'd410;

	typedef struct packed {
		logic [DelayWidth-1:0] short_low;
		logic [DelayWidth-1:0] one_recover;
		logic [DelayWidth-1:0] zero_low;
		logic [DelayWidth-1:0] zero_recover;
		logic [DelayWidth-1:0] read_sample;
		logic [DelayWidth-1:0] reset_low;
		logic [DelayWidth-1:0] presence_sample;
		logic [DelayWidth-1:0] presence_tail;
	} cfg_t;

	typedef struct packed {
		logic                 cmd_valid;
		logic [OpWidth-1:0]   op;
		logic [LineWidth-1:0] lane_mask;
		logic [LineWidth-1:0] line_level;
	} in_item_t;

	typedef struct packed {
		logic [LineWidth-1:0] drive_low;
		logic                 busy_res;
		logic                 done_res;
		logic [LineWidth-1:0] slot_result;
	} out_item_t;

endpackage

FILE: hdl/owbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// Bank of eight 10-bit slot timing registers, written by index.
// ----------------------------------------------------------------------------
module owbm_cfg_regs
	import owbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [IndexWidth-1:0] wr_index,
	input  logic [DelayWidth-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_low       <= RST_SHORT_LOW;
			cfg_q.one_recover     <= RST_ONE_RECOVER;
			cfg_q.zero_low        <= RST_ZERO_LOW;
			cfg_q.zero_recover    <= RST_ZERO_RECOVER;
			cfg_q.read_sample     <= RST_READ_SAMPLE;
			cfg_q.reset_low       <= RST_RESET_LOW;
			cfg_q.presence_sample <= RST_PRESENCE_SAMPLE;
			cfg_q.presence_tail   <= RST_PRESENCE_TAIL;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SHORT_LOW:       cfg_q.short_low       <= wr_data;
				REG_ONE_RECOVER:     cfg_q.one_recover     <= wr_data;
				REG_ZERO_LOW:        cfg_q.zero_low        <= wr_data;
				REG_ZERO_RECOVER:    cfg_q.zero_recover    <= wr_data;
				REG_READ_SAMPLE:     cfg_q.read_sample     <= wr_data;
				REG_RESET_LOW:       cfg_q.reset_low       <= wr_data;
				REG_PRESENCE_SAMPLE: cfg_q.presence_sample <= wr_data;
				default:             cfg_q.presence_tail   <= wr_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/owbm_slot_engine.sv
// ----------------------------------------------------------------------------
// owbm_slot_engine
// Slot state and the per-tick update: start, phase countdown, sampling.
// The result of a tick is combinational; state moves on when en is high.
// ----------------------------------------------------------------------------
module owbm_slot_engine
	import owbm_pkg::*;
#(
	parameter int LANES               = 8,
	parameter int READ_RECOVERY_TICKS = 55
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t res
);

	localparam logic [LineWidth-1:0]  LaneBits = LineWidth'((16'd1 << LANES) - 16'd1);
	localparam logic [DelayWidth-1:0] RecTicks = DelayWidth'(READ_RECOVERY_TICKS % 1024);

	typedef enum logic [1:0] {PH_IDLE, PH_LOW, PH_RELEASE, PH_TAIL} phase_t;

	typedef struct packed {
		phase_t                ph;
		logic [DelayWidth-1:0] cnt;
		logic [LineWidth-1:0]  smp;
		logic                  done;
	} slot_t;

	phase_t                phase_q;
	logic [DelayWidth-1:0] count_q;
	logic [OpWidth-1:0]    op_q;
	logic [LineWidth-1:0]  mask_q;
	logic [LineWidth-1:0]  sampled_q;

	slot_t                 slot;
	logic [OpWidth-1:0]    aop;
	logic [LineWidth-1:0]  amask;
	logic [LineWidth-1:0]  drive;

	function automatic logic [DelayWidth-1:0] low_len(logic [OpWidth-1:0] op, cfg_t c);
		logic [DelayWidth-1:0] len;
		unique case (op)
			OP_WRITE0:         len = c.zero_low;
			OP_WRITE1, OP_READ: len = c.short_low;
			default:           len = c.reset_low;
		endcase
		return len;
	endfunction

	function automatic logic [DelayWidth-1:0] release_len(logic [OpWidth-1:0] op, cfg_t c);
		logic [DelayWidth-1:0] len;
		unique case (op)
			OP_INIT:   len = c.reset_low;
			OP_WRITE0: len = c.zero_recover;
			OP_WRITE1: len = c.one_recover;
			OP_READ:   len = c.read_sample;
			default:   len = c.presence_sample;
		endcase
		return len;
	endfunction

	// leave every phase with an expired count; at most three in a row
	function automatic slot_t advance(slot_t s_in, logic [OpWidth-1:0] op,
			logic [LineWidth-1:0] mask, logic [LineWidth-1:0] line, cfg_t c);
		slot_t s;
		s = s_in;
		for (int i = 0; i < 3; i++) begin
			if (s.ph != PH_IDLE && s.cnt == '0) begin
				unique case (s.ph)
					PH_LOW: begin
						s.ph  = PH_RELEASE;
						s.cnt = release_len(op, c);
					end
					PH_RELEASE: begin
						if (op == OP_READ) begin
							s.smp = line & mask;
							s.ph  = PH_TAIL;
							s.cnt = RecTicks;
						end else if (op == OP_PRESENCE) begin
							s.smp = ~line & mask;
							s.ph  = PH_TAIL;
							s.cnt = c.presence_tail;
						end else begin
							s.ph   = PH_IDLE;
							s.done = 1'b1;
						end
					end
					default: begin
						s.ph   = PH_IDLE;
						s.done = 1'b1;
					end
				endcase
			end
		end
		return s;
	endfunction

	always_comb begin
		slot.ph   = phase_q;
		slot.cnt  = count_q;
		slot.smp  = sampled_q;
		slot.done = 1'b0;
		aop       = op_q;
		amask     = mask_q;
		drive     = '0;
		// commands are only taken while idle; unknown codes are dropped
		if (phase_q == PH_IDLE && item.cmd_valid && item.op <= OP_PRESENCE) begin
			aop      = item.op;
			amask    = item.lane_mask & LaneBits;
			slot.smp = '0;
			if (item.op == OP_INIT) begin
				slot.ph  = PH_RELEASE;
				slot.cnt = release_len(item.op, cfg);
			end else begin
				slot.ph  = PH_LOW;
				slot.cnt = low_len(item.op, cfg);
			end
			slot = advance(slot, aop, amask, item.line_level, cfg);
		end
		if (slot.ph != PH_IDLE) begin
			if (slot.ph == PH_LOW) begin
				drive = amask;
			end
			slot.cnt = slot.cnt - DelayWidth'(1);
			slot     = advance(slot, aop, amask, item.line_level, cfg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			count_q   <= '0;
			op_q      <= '0;
			mask_q    <= '0;
			sampled_q <= '0;
		end else if (en) begin
			phase_q   <= slot.ph;
			count_q   <= slot.cnt;
			op_q      <= aop;
			mask_q    <= amask;
			sampled_q <= slot.smp;
		end
	end

	assign res.drive_low   = drive;
	assign res.busy_res    = (slot.ph != PH_IDLE);
	assign res.done_res    = slot.done;
	assign res.slot_result = slot.done ? slot.smp : '0;

`ifndef ASSERT_OFF
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |-> count_q != '0)
		else $error("slot in progress with expired count");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.done_res |-> !res.busy_res)
		else $error("slot done while still busy");

	a_mask_held: assert property (@(posedge clk) disable iff (!arst_n)
		(en && phase_q != PH_IDLE) |=> mask_q == $past(mask_q))
		else $error("lane mask changed during a slot");

	a_sample_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(sampled_q & ~mask_q) == '0)
		else $error("sampled bit outside lane mask");

	a_result_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.slot_result != '0 |-> res.done_res)
		else $error("slot result without done");
`endif

endmodule

FILE: hdl/onewire_bit_slot_master_top.sv
// An accepted item passes through the input register, then the result register,
// before its result is offered on m_axis. Throughput: one item per cycle while
// m_axis_tready is high; the slot engine updates its state once per tick.
// Reset: arst_n clears both pipeline stages and the slot state to idle, and
// loads the delay registers with their defaults.
// ----------------------------------------------------------------------------
// onewire_bit_slot_master_top
// 1-Wire bus master at bit-slot level: each stream item is one tick.
// ----------------------------------------------------------------------------
module onewire_bit_slot_master_top
	import owbm_pkg::*;
#(
	parameter int LANES               = 8,
	parameter int READ_RECOVERY_TICKS = 55
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [0] cmd_valid, [3:1] op, [11:4] lane_mask, [19:12] line_level, [23:20] zero
	input  logic [23:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] drive_low, [8] busy_res, [9] done_res, [17:10] slot_result, [23:18] zero
	output logic [23:0]           m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IndexWidth-1:0] cfg_index,
	input  logic [DelayWidth-1:0] cfg_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	out_item_t res;
	cfg_t      cfg;
	logic      fire_s1;

	// s1 moves into the result register when that is empty or being drained
	assign fire_s1       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (fire_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.cmd_valid  <= s_axis_tdata[0];
			item_s1.op         <= s_axis_tdata[3:1];
			item_s1.lane_mask  <= s_axis_tdata[11:4];
			item_s1.line_level <= s_axis_tdata[19:12];
		end
		if (fire_s1) begin
			res_s2 <= res;
		end
	end

	owbm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	owbm_slot_engine #(
		.LANES               (LANES),
		.READ_RECOVERY_TICKS (READ_RECOVERY_TICKS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'b0, res_s2.slot_result, res_s2.done_res,
		res_s2.busy_res, res_s2.drive_low};

endmodule
